// ----- design/mas_pkg.sv -----
// mas_pkg: shared types and constants for the massage actuator sequencer
// holds the csr register indexes, the configuration struct and field layout
// no dependencies
`timescale 1ns / 1ps

package mas_pkg;

   // counter width default and level range
   localparam int          TIME_BITS_DEFAULT = 16;
   localparam logic [2:0]  LEVEL_COUNT       = 3'd3;

   // layout of the per-level duration registers
   localparam int FIELD_BITS = 16;
   localparam int REG_BITS   = 3 * FIELD_BITS;

   // csr register indexes
   typedef enum logic [1:0] {
      CSR_EXTEND_TICKS  = 2'd0,
      CSR_PAUSE_TICKS   = 2'd1,
      CSR_RETRACT_TICKS = 2'd2,
      CSR_MARGIN_TICKS  = 2'd3
   } csr_index_type;

   // configuration handed from the csr block to the sequencer
   typedef struct packed {
      logic [REG_BITS-1:0]   extend_ticks;
      logic [REG_BITS-1:0]   pause_ticks;
      logic [REG_BITS-1:0]   retract_dur;
      logic [FIELD_BITS-1:0] margin_ticks;
   } cfg_type;

endpackage

// ----- design/mas_csr.sv -----
// mas_csr: configuration registers of the massage actuator sequencer
// plain write port, no read-back; depends on mas_pkg
`timescale 1ns / 1ps

module mas_csr
   import mas_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [REG_BITS-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;

   // register writes, one register per index
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_EXTEND_TICKS:  cfg_ff.extend_ticks  <= csr_wdata;
            CSR_PAUSE_TICKS:   cfg_ff.pause_ticks   <= csr_wdata;
            CSR_RETRACT_TICKS: cfg_ff.retract_dur   <= csr_wdata;
            CSR_MARGIN_TICKS:  cfg_ff.margin_ticks  <= csr_wdata[FIELD_BITS-1:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/massage_actuator_sequencer_core.sv -----
// massage_actuator_sequencer_core: top level of the actuator phase sequencer
// instantiates mas_csr; depends on mas_pkg
`timescale 1ns / 1ps

// Each request item is either one time tick (req_cmd = 0) or a level command
// (req_cmd = 1, req_level 0..3). Every accepted item yields exactly one
// response item carrying the drive, phase and levels after that item. The
// phase state machine and its tick counter update in a single pass of compare
// and add logic, and the state registers double as the response register, so
// a new item is taken every cycle while the response side keeps up and
// whenever the response register is empty. Durations are to be written through
// the csr port while no item is in flight; the block itself does not enforce it.
module massage_actuator_sequencer_core
   import mas_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [REG_BITS-1:0] csr_wdata,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [1:0]          req_level,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_drive,
   output logic [2:0]          rsp_phase,
   output logic [1:0]          rsp_running_level,
   output logic [1:0]          rsp_pending_level
);

   localparam int WIDE_BITS = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE         = 3'd0,
      PH_EXTEND       = 3'd1,
      PH_PAUSE        = 3'd2,
      PH_RETRACT      = 3'd3,
      PH_STOP_WAIT    = 3'd4,
      PH_STOP_RETRACT = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      DRV_STOP = 2'd0,
      DRV_PUSH = 2'd1,
      DRV_PULL = 2'd2
   } drive_type;

   cfg_type cfg;

   mas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // clamp a 16-bit duration to the counter range
   function automatic logic [TIME_BITS-1:0] sat_time(input logic [FIELD_BITS-1:0] v);
      logic [WIDE_BITS-1:0] wide_v;
      logic [WIDE_BITS-1:0] wide_max;
      wide_v   = WIDE_BITS'(v);
      wide_max = WIDE_BITS'(TIME_MAX);
      return (wide_v > wide_max) ? TIME_MAX : TIME_BITS'(wide_v);
   endfunction

   // duration field of one level, zero for level 0 and unused levels
   function automatic logic [TIME_BITS-1:0] ticks_for(input logic [REG_BITS-1:0] regv,
                                                      input logic [1:0] lvl);
      logic [FIELD_BITS-1:0] field;
      case (lvl)
         2'd1:    field = regv[FIELD_BITS-1:0];
         2'd2:    field = regv[2*FIELD_BITS-1:FIELD_BITS];
         2'd3:    field = regv[3*FIELD_BITS-1:2*FIELD_BITS];
         default: field = '0;
      endcase
      if ({1'b0, lvl} > LEVEL_COUNT) begin
         field = '0;
      end
      return sat_time(field);
   endfunction

   phase_type            phase_ff,   phase_in;
   drive_type            drive_ff,   drive_in;
   logic [1:0]           cur_lvl_ff, cur_lvl_in;
   logic [1:0]           want_lvl_ff, want_lvl_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TIME_BITS:0]   length_ff,  length_in;
   logic [TIME_BITS:0]   stop_ret_ff, stop_ret_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic [TIME_BITS:0]   spent;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // ticks already spent extending, capped at the extend length
   assign spent = ({1'b0, elapsed_ff} < length_ff) ? {1'b0, elapsed_ff} : length_ff;

   // next state: apply the command or tick, then one end-of-phase check
   always_comb begin
      phase_in    = phase_ff;
      drive_in    = drive_ff;
      cur_lvl_in  = cur_lvl_ff;
      want_lvl_in = want_lvl_ff;
      elapsed_in  = elapsed_ff;
      length_in   = length_ff;
      stop_ret_in = stop_ret_ff;

      if (req_cmd) begin
         if ({1'b0, req_level} <= LEVEL_COUNT) begin
            case (phase_ff)
               PH_IDLE: begin
                  want_lvl_in = req_level;
                  if (req_level != 2'd0) begin
                     phase_in   = PH_EXTEND;
                     cur_lvl_in = req_level;
                     elapsed_in = '0;
                     length_in  = {1'b0, ticks_for(cfg.extend_ticks, req_level)};
                     drive_in   = DRV_PUSH;
                  end
               end
               PH_EXTEND: begin
                  if (req_level == 2'd0) begin
                     // early stop
                     want_lvl_in = 2'd0;
                     stop_ret_in = spent + {1'b0, sat_time(cfg.margin_ticks)};
                     phase_in    = PH_STOP_WAIT;
                     elapsed_in  = '0;
                     length_in   = {1'b0, ticks_for(cfg.pause_ticks, cur_lvl_ff)};
                     drive_in    = DRV_STOP;
                  end else if (req_level > cur_lvl_ff) begin
                     // raise intensity without restarting the timer
                     cur_lvl_in  = req_level;
                     want_lvl_in = req_level;
                     length_in   = {1'b0, ticks_for(cfg.extend_ticks, req_level)};
                  end else begin
                     want_lvl_in = req_level;
                  end
               end
               default: want_lvl_in = req_level;
            endcase
         end
      end else if (elapsed_ff != TIME_MAX) begin
         elapsed_in = elapsed_ff + 1'b1;
      end

      // end of phase check on the updated timer
      if (phase_in != PH_IDLE &&
          ({1'b0, elapsed_in} >= length_in || elapsed_in == TIME_MAX)) begin
         case (phase_in)
            PH_EXTEND: begin
               phase_in   = PH_PAUSE;
               elapsed_in = '0;
               length_in  = {1'b0, ticks_for(cfg.pause_ticks, cur_lvl_in)};
               drive_in   = DRV_STOP;
            end
            PH_PAUSE: begin
               phase_in   = PH_RETRACT;
               elapsed_in = '0;
               length_in  = {1'b0, ticks_for(cfg.retract_dur, cur_lvl_in)};
               drive_in   = DRV_PULL;
            end
            PH_STOP_WAIT: begin
               phase_in   = PH_STOP_RETRACT;
               elapsed_in = '0;
               length_in  = stop_ret_in;
               drive_in   = DRV_PULL;
            end
            PH_RETRACT, PH_STOP_RETRACT: begin
               if (want_lvl_in != 2'd0) begin
                  phase_in   = PH_EXTEND;
                  cur_lvl_in = want_lvl_in;
                  elapsed_in = '0;
                  length_in  = {1'b0, ticks_for(cfg.extend_ticks, want_lvl_in)};
                  drive_in   = DRV_PUSH;
               end else begin
                  phase_in    = PH_IDLE;
                  cur_lvl_in  = 2'd0;
                  length_in   = '0;
                  stop_ret_in = '0;
                  drive_in    = DRV_STOP;
               end
            end
            default: begin
               phase_in    = PH_IDLE;
               cur_lvl_in  = 2'd0;
               length_in   = '0;
               stop_ret_in = '0;
               drive_in    = DRV_STOP;
            end
         endcase
      end
   end

   // response valid: set on accept, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         drive_ff     <= DRV_STOP;
         cur_lvl_ff   <= '0;
         want_lvl_ff  <= '0;
         elapsed_ff   <= '0;
         length_ff    <= '0;
         stop_ret_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            drive_ff    <= drive_in;
            cur_lvl_ff  <= cur_lvl_in;
            want_lvl_ff <= want_lvl_in;
            elapsed_ff  <= elapsed_in;
            length_ff   <= length_in;
            stop_ret_ff <= stop_ret_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_phase         = phase_ff;
   assign rsp_running_level = cur_lvl_ff;
   assign rsp_pending_level = want_lvl_ff;

   // motor pushes exactly while extending
   a_push_in_extend: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXTEND) == (drive_ff == DRV_PUSH))
      else $error("drive push does not match extend phase");

   // idle has no running level, any other phase has one
   a_idle_level: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (cur_lvl_ff == 2'd0))
      else $error("running level inconsistent with phase");

   // a held response blocks new items
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("item accepted over a pending response");

   // response state only moves when an item is accepted
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(cur_lvl_ff) && $stable(want_lvl_ff))
      else $error("state changed without an item");

endmodule
